// File: sv/pfe_pkg.sv
// Package: shared types, codes and widths for the postfix evaluator.
package pfe_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned ValW = 31;
  localparam int unsigned StackDepthDef = 16;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_OPER = 2'd1,
    REQ_FIN  = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]      req;
    logic [ValW-1:0] val;
    logic [2:0]      code;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [2:0]       status;
    logic             fin;
  } res_t;
endpackage

// File: sv/pfe_queue.sv
// Two-entry queue between the front and back parts.
module pfe_queue import pfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !rd) else $error("read from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !wr) else $error("write to full queue");
endmodule

// File: sv/pfe_back.sv
// Back part: operand stack, sequencer, shared multiplier and divider.
module pfe_back import pfe_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);
  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CW = $clog2(StackDepth + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_POW  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e           state_q;
  logic [DataW-1:0] stk_q [StackDepth];
  logic [DataW-1:0] rdata_q, left_q, right_q;
  logic [CW-1:0]    cnt_q;
  logic [AW-1:0]    raddr;
  logic             ren;
  cmd_t             cmd_q;
  res_t             res_q;
  logic             rvalid_q;
  logic [5:0]       step_q;
  logic [DataW-1:0] acc_q, sq_q, quo_q, rem_q, ua_q, ub_q;
  logic             neg_q, pow_phase_q;
  logic [DataW-1:0] mul_a, mul_b, mul_p_q;
  logic [DataW:0]   rem_sh, rem_sub;
  logic             wen;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;

  assign cmd_ready_o = (state_q == S_IDLE) && !rvalid_q;
  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (ren) rdata_q <= stk_q[raddr];
    if (wen) stk_q[waddr] <= wdata;
    mul_p_q <= mul_a * mul_b;
  end

  assign rem_sh  = {rem_q, ua_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, ub_q};

  always_comb begin
    ren = 1'b0; raddr = '0;
    if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o && cnt_q != '0) begin
      ren = 1'b1; raddr = AW'(cnt_q - 1'b1);
    end else if (state_q == S_RD1) begin
      ren = 1'b1; raddr = AW'(cnt_q - CW'(2));
    end
    mul_a = pow_phase_q ? sq_q : acc_q;
    mul_b = sq_q;
    if (state_q == S_EXEC) begin mul_a = left_q; mul_b = right_q; end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rvalid_q <= 1'b0; wen <= 1'b0;
    end else begin
      wen <= 1'b0;
      if (rvalid_q && res_ready_i) rvalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (cmd_valid_i && cmd_ready_o) begin
          cmd_q <= cmd_i;
          res_q <= '{value: '0, status: ST_OK, fin: 1'b0};
          case (cmd_i.req)
            REQ_PUSH: begin
              if (cnt_q >= CW'(StackDepth)) res_q.status <= ST_OVER;
              else begin
                wen <= 1'b1; waddr <= AW'(cnt_q);
                wdata <= {1'b0, cmd_i.val}; cnt_q <= cnt_q + 1'b1;
              end
              rvalid_q <= 1'b1;
            end
            REQ_OPER: begin
              if (cmd_i.code > OP_POW) rvalid_q <= 1'b1;
              else if (cnt_q < CW'(2)) begin
                res_q.status <= ST_UNDER; rvalid_q <= 1'b1;
              end else state_q <= S_RD1;
            end
            REQ_FIN: begin
              res_q.fin <= 1'b1;
              if (cnt_q == '0) begin
                res_q.status <= ST_EMPTY; rvalid_q <= 1'b1;
              end else state_q <= S_RD2;
              cnt_q <= '0;
            end
            default: rvalid_q <= 1'b1;
          endcase
        end
        S_RD1: begin
          right_q <= rdata_q; state_q <= S_RD2;
        end
        S_RD2: begin
          if (cmd_q.req == REQ_FIN) begin
            res_q.value <= rdata_q; rvalid_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            left_q <= rdata_q;
            ua_q <= rdata_q[DataW-1] ? -rdata_q : rdata_q;
            ub_q <= right_q[DataW-1] ? -right_q : right_q;
            neg_q <= rdata_q[DataW-1] ^ right_q[DataW-1];
            acc_q <= 32'd1; sq_q <= rdata_q; rem_q <= '0;
            step_q <= '0; pow_phase_q <= 1'b0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.code)
            OP_ADD: begin res_q.value <= left_q + right_q; state_q <= S_OUT; end
            OP_SUB: begin res_q.value <= left_q - right_q; state_q <= S_OUT; end
            OP_MUL: begin step_q <= step_q + 1'b1;
              if (step_q[0]) begin res_q.value <= mul_p_q; state_q <= S_OUT; end
            end
            OP_DIV: if (right_q == '0) begin
              res_q.status <= ST_DIVZ; rvalid_q <= 1'b1; state_q <= S_IDLE;
            end else state_q <= S_DIV;
            default: begin
              if (right_q[DataW-1]) begin
                res_q.value <= (left_q == 32'd1) ? 32'd1 :
                  (left_q == '1) ? (right_q[0] ? '1 : 32'd1) : '0;
                state_q <= S_OUT;
              end else state_q <= S_POW;
            end
          endcase
        end
        S_DIV: begin
          ua_q <= {ua_q[DataW-2:0], 1'b0};
          if (!rem_sub[DataW]) begin
            rem_q <= rem_sub[DataW-1:0]; quo_q <= {quo_q[DataW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[DataW-1:0]; quo_q <= {quo_q[DataW-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == 6'd32) begin
            res_q.value <= neg_q ? -quo_q : quo_q; state_q <= S_OUT;
          end
        end
        S_POW: begin
          // each exponent bit: multiply acc, then square
          step_q <= step_q + 1'b1;
          case (step_q[1:0])
            2'd1: begin
              if (right_q[0]) acc_q <= mul_p_q;
              pow_phase_q <= 1'b1;
            end
            2'd3: begin
              sq_q <= mul_p_q; pow_phase_q <= 1'b0;
              right_q <= {1'b0, right_q[DataW-1:1]};
              if (right_q[DataW-1:1] == '0) state_q <= S_OUT;
            end
            default: ;
          endcase
          if (step_q[1:0] == 2'd3 && right_q[DataW-1:1] == '0)
            res_q.value <= acc_q;
        end
        S_OUT: begin
          wen <= 1'b1; waddr <= AW'(cnt_q - CW'(2)); wdata <= res_q.value;
          cnt_q <= cnt_q - 1'b1; rvalid_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(StackDepth)) else $error("stack count exceeds depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && !res_ready_i) |=> $stable(res_q)) else $error("result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_ready_o) else $error("accept while busy");
endmodule

// File: sv/pfe_front.sv
// Front part: accept and classify incoming stream items.
module pfe_front import pfe_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);
  assign cmd_o.req     = s_axis_tuser;
  assign cmd_o.val     = s_axis_tdata[30:0];
  assign cmd_o.code    = s_axis_tdata[33:31];
  assign cmd_valid_o   = s_axis_tvalid;
  assign s_axis_tready = cmd_ready_i;
endmodule

// File: sv/postfix_expression_evaluator_core.sv
// Top level: postfix expression evaluator with operand stack.
// Usage:
//  The slave stream carries one request per item: tuser holds req_type,
//  tdata holds operand_value and operator_code from the lowest bit up.
//  Every request yields exactly one result item on the master stream:
//  tdata holds result_value, tuser holds status, tlast marks is_final.
//  A two-entry queue decouples intake from execution. The execution unit
//  takes one item at a time: push, stack errors and ignored requests are
//  answered without leaving S_IDLE; finish reads the top of the stack;
//  operators read both operands first. A nonzero divide runs one quotient
//  bit a cycle over 33 steps, power one exponent bit at a time over up to
//  31 bits on the shared multiplier. The next request is accepted in the
//  cycle after the result leaves.
//  The stack is a memory with one registered read port, so an operator
//  reads its two operands one after the other.
//  Reset empties the stack count; stack contents stay undefined until
//  pushed. When the receiver stalls, the result is held and the execution
//  unit waits; the queue keeps accepting up to two items.
module postfix_expression_evaluator_core import pfe_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operand_value, operator_code
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value
  output logic [2:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);
  logic fv, fr, bv, br;
  cmd_t fc, bc;
  res_t r;

  pfe_front u_front (
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .cmd_valid_o(fv), .cmd_ready_i(fr), .cmd_o(fc));

  pfe_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(fv), .in_ready_o(fr),
    .in_cmd_i(fc), .out_valid_o(bv), .out_ready_i(br), .out_cmd_o(bc));

  pfe_back #(.StackDepth(StackDepth)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_valid_i(bv), .cmd_ready_o(br),
    .cmd_i(bc), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(r));

  assign m_axis_tdata = r.value;
  assign m_axis_tuser = r.status;
  assign m_axis_tlast = r.fin;
endmodule
